// ===== rtl/zsm_pkg.sv =====
`default_nettype none

package zsm_pkg;

    localparam int WINDOW = 5;
    localparam int DATA_W = 16;
    localparam int AGE_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IDX_W  = AGE_W;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
        logic [AGE_W-1:0]  age;
    } t_entry;

    // what a cell shows its neighbors
    typedef struct packed {
        t_entry ent;
        logic   surv;
        logic   gt;
        logic   del_le;
    } t_link;

endpackage

`default_nettype wire

// ===== rtl/zsm_if.sv =====
`default_nettype none

interface zsm_in_if import zsm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface zsm_out_if import zsm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink (input valid, input median, output ready);
endinterface

`default_nettype wire

// ===== rtl/zsm_cell.sv =====
`default_nettype none

module zsm_cell import zsm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [DATA_W-1:0] i_x,
    input  wire logic              i_ins,
    input  wire logic              i_slot_open,
    input  wire t_link             i_left,
    input  wire t_link             i_right,
    output t_link                  o_link,
    output t_entry                 o_next
);

    t_entry r_ent;
    t_entry n_ent;
    logic   w_exp;
    logic   w_take_r;
    logic   w_keep;
    logic   w_take_l;

    always_comb begin
        w_exp         = r_ent.valid && (r_ent.age == AGE_W'(WINDOW - 1));
        o_link.ent    = r_ent;
        o_link.surv   = r_ent.valid && !w_exp;
        // with no new entry nothing sits above the insertion point
        o_link.gt     = i_ins && (r_ent.value > i_x);
        o_link.del_le = i_left.del_le | w_exp;

        // survivor above the deleted entry and not above the new one moves down
        w_take_r = i_right.surv && o_link.del_le && !i_right.gt;
        w_keep   = o_link.surv && (i_left.del_le == o_link.gt);
        // survivor above the new one with no deletion below moves up
        w_take_l = i_left.surv && i_left.gt && !i_left.del_le;

        n_ent       = r_ent;
        n_ent.valid = 1'b0;
        if (w_take_r) begin
            n_ent     = i_right.ent;
            n_ent.age = i_right.ent.age + AGE_W'(1);
        end else if (w_keep) begin
            n_ent.valid = 1'b1;
            n_ent.age   = r_ent.age + AGE_W'(1);
        end else if (w_take_l) begin
            n_ent     = i_left.ent;
            n_ent.age = i_left.ent.age + AGE_W'(1);
        end else if (i_ins && i_slot_open) begin
            n_ent.valid = 1'b1;
            n_ent.value = i_x;
            n_ent.age   = '0;
        end
        o_next = n_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else if (i_step) begin
            r_ent <= n_ent;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/zero_skipping_window_median_top.sv =====
// zero-skipping sliding-window median over the last WINDOW samples
//
// input channel i_in carries one 16-bit sample per transaction; a zero sample
// counts as a slot of the window but holds no reading. output channel o_out
// carries one median per accepted sample: the upper-middle of the non-zero
// samples in the window, or zero when there are none.
//
// the window is kept as a row of cells sorted by value, each tagged with its
// age; each accepted sample inserts the new one and drops the expiring one together.
// the median is registered and appears on o_out in the cycle after the sample is taken.
// throughput: one sample per cycle while o_out is not stalled, set by the cell update and
// the one output register.
// the block takes a new sample whenever the output register is empty or is
// being emptied in the same cycle; while the receiver stalls with a result
// waiting, i_in.ready is low and the window holds.
// reset empties the window and the output register.
`default_nettype none

module zero_skipping_window_median_top import zsm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    zsm_in_if.sink     i_in,
    zsm_out_if.source  o_out
);

    localparam t_link C_NULL = '0;

    t_link             w_link [WINDOW];
    t_entry            w_next [WINDOW];
    logic              w_acc;
    logic              w_ins;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  w_mid;
    logic [DATA_W-1:0] w_med;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_med;
    logic              w_packed;
    logic              w_sorted;

    assign i_in.ready   = !r_ovalid || o_out.ready;
    assign o_out.valid  = r_ovalid;
    assign o_out.median = r_med;

    always_comb begin
        w_acc = i_in.valid && i_in.ready;
        w_ins = i_in.sample != '0;
        n_cnt = r_cnt - CNT_W'(w_link[WINDOW-1].del_le) + CNT_W'(w_ins);
        w_mid = IDX_W'(n_cnt >> 1);
        w_med = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (IDX_W'(i) == w_mid && n_cnt != '0) begin
                w_med = w_next[i].value;
            end
        end
    end

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        t_link w_left;
        t_link w_right;
        if (g == 0) begin : g_first
            assign w_left = C_NULL;
        end else begin : g_inner_l
            assign w_left = w_link[g-1];
        end
        if (g == WINDOW - 1) begin : g_last
            assign w_right = C_NULL;
        end else begin : g_inner_r
            assign w_right = w_link[g+1];
        end

        zsm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_step      (w_acc),
            .i_x         (i_in.sample),
            .i_ins       (w_ins),
            .i_slot_open (CNT_W'(g) < n_cnt),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_link      (w_link[g]),
            .o_next      (w_next[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_cnt    <= n_cnt;
                r_ovalid <= 1'b1;
                r_med    <= w_med;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        w_packed = 1'b1;
        w_sorted = 1'b1;
        for (int i = 0; i < WINDOW; i++) begin
            if (w_link[i].ent.valid != (CNT_W'(i) < r_cnt)) begin
                w_packed = 1'b0;
            end
        end
        for (int i = 0; i < WINDOW - 1; i++) begin
            if (w_link[i+1].ent.valid && (w_link[i].ent.value > w_link[i+1].ent.value)) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW))
        else $error("cell count beyond window");

    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_packed)
        else $error("occupied cells not packed at the low end");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sorted)
        else $error("cells out of order");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_cnt == '0 && i_in.sample == '0) |=> (o_out.valid && o_out.median == '0))
        else $error("empty window must give zero");

endmodule

`default_nettype wire
